[src/rpru_pkg.sv]
// ----------------------------------------------------------------------------
// rpru_pkg
// Shared constants, register codes and control types for the RAID parity
// recovery and unpack block.
// ----------------------------------------------------------------------------
package rpru_pkg;

  localparam int MAX_DISKS           = 8;
  localparam int DEF_MAX_BLOCK_BITS  = 32;

  localparam int DISK_W     = 8;   // disk_bits / unknown_mask width
  localparam int DISK_IDX_W = 3;   // selects one disk of DISK_W
  localparam int DCNT_W     = 4;   // disk_count width
  localparam int BB_W       = 6;   // block_bits width
  localparam int DIGIT_W    = 4;
  localparam int FILL_W     = 3;   // nibble fill, 0..4

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_ODD = 2'd2;

  localparam logic [DCNT_W-1:0] RST_DISK_COUNT = 4'd3;
  localparam logic [BB_W-1:0]   RST_BLOCK_BITS = 6'd4;

  localparam logic [FILL_W-1:0] FILL_FULL = 3'd4;

  typedef struct packed {
    logic in_ready;    // input channel open
    logic accept;      // take the offered column
    logic rd_first;    // fetch first column of the stripe
    logic push;        // shift one data bit into the nibble
    logic final_emit;  // emit the closing digit of the set
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic drain;       // offered column completes a stripe
    logic eos;         // stripe being drained ends the set
    logic stripe_done; // current bit is the last of the stripe
    logic fill_full;   // nibble holds four bits
    logic out_free;    // output register can load this cycle
  } status_t;

endpackage

[src/rpru_if.sv]
// ----------------------------------------------------------------------------
// rpru_if
// Handshake channels: column input, digit output and register writes.
// ----------------------------------------------------------------------------
interface rpru_col_if;
  logic                        valid;
  logic                        ready;
  logic [rpru_pkg::DISK_W-1:0] disk_bits;
  logic [rpru_pkg::DISK_W-1:0] unknown_mask;
  logic                        end_of_set;

  modport source (output valid, output disk_bits, output unknown_mask,
                  output end_of_set, input ready);
  modport sink   (input valid, input disk_bits, input unknown_mask,
                  input end_of_set, output ready);
endinterface

interface rpru_dig_if;
  logic                         valid;
  logic                         ready;
  logic [rpru_pkg::DIGIT_W-1:0] hex_digit;
  logic                         set_invalid;
  logic                         last;

  modport source (output valid, output hex_digit, output set_invalid,
                  output last, input ready);
  modport sink   (input valid, input hex_digit, input set_invalid,
                  input last, output ready);
endinterface

interface rpru_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rpru_pkg::CFG_IDX_W-1:0]  addr;
  logic [rpru_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[src/raid_parity_recover_unpack_top.sv]
// ----------------------------------------------------------------------------
// raid_parity_recover_unpack_top
// RAID parity erasure recovery: checks and repairs bit columns, buffers a
// stripe, then unpacks the data disks into MSB-first hex digits.
// ----------------------------------------------------------------------------
//   channel  dir  handshake      payload
//   column   in   valid/ready    disk_bits, unknown_mask, end_of_set
//   digit    out  valid/ready    hex_digit, set_invalid, last
//   cfg      in   valid/ready    addr (register index), data
//
// A column that does not close a stripe is stored. A column that closes
// a stripe also starts the drain: one stripe buffer read per data bit, and
// one bit packed per cycle unless stalled. End of set adds the closing digit.
// Reset (rst, synchronous) clears control state and config registers; the
// stripe buffer needs no clearing. A held digit stalls the bit walk only
// when the next full nibble must leave. cfg is always ready.
// ----------------------------------------------------------------------------
module raid_parity_recover_unpack_top #(
  parameter int MAX_BLOCK_BITS = rpru_pkg::DEF_MAX_BLOCK_BITS
) (
  input  logic       clk,
  input  logic       rst,
  rpru_col_if.sink   column,
  rpru_dig_if.source digit,
  rpru_cfg_if.sink   cfg
);
  import rpru_pkg::*;

  cmd_t    cmd;
  status_t status;

  rpru_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rpru_datapath #(
    .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .column (column),
    .digit  (digit),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule

[src/rpru_ctrl.sv]
// ----------------------------------------------------------------------------
// rpru_ctrl
// Sequencer: takes a column, then walks the stripe one data bit per cycle,
// stalled while a full nibble waits, and closes the set with a final digit.
// ----------------------------------------------------------------------------
module rpru_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  rpru_pkg::status_t status,
  output rpru_pkg::cmd_t    cmd
);
  import rpru_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_PUSH  = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd            = '0;
    cmd.in_ready   = (state == S_IDLE);
    cmd.accept     = (state == S_IDLE) && status.in_valid;
    cmd.rd_first   = (state == S_READ);
    // a full nibble must leave before the next bit goes in
    cmd.push       = (state == S_PUSH) && (!status.fill_full || status.out_free);
    cmd.final_emit = (state == S_FINAL) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && status.drain) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (cmd.push && status.stripe_done) begin
          state_next = status.eos ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (cmd.final_emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/rpru_datapath.sv]
// ----------------------------------------------------------------------------
// rpru_datapath
// Column check and repair, stripe buffer, bit walk over disks and columns,
// nibble packing and the output register. Holds the config registers.
// ----------------------------------------------------------------------------
module rpru_datapath #(
  parameter int MAX_BLOCK_BITS = rpru_pkg::DEF_MAX_BLOCK_BITS
) (
  input  logic              clk,
  input  logic              rst,
  rpru_col_if.sink          column,
  rpru_dig_if.source        digit,
  rpru_cfg_if.sink          cfg,
  input  rpru_pkg::cmd_t    cmd,
  output rpru_pkg::status_t status
);
  import rpru_pkg::*;

  localparam int AW = (MAX_BLOCK_BITS > 1) ? $clog2(MAX_BLOCK_BITS) : 1;

  // config registers
  logic [DCNT_W-1:0] disk_count;
  logic [BB_W-1:0]   block_bits;
  logic              parity_odd;

  // stripe buffer
  logic [DISK_W-1:0] stripe_mem [MAX_BLOCK_BITS];
  logic [DISK_W-1:0] rdata;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;

  // set state
  logic [AW-1:0]         col_idx;
  logic [DISK_IDX_W-1:0] parity_disk;
  logic [DIGIT_W-1:0]    nibble_accum;
  logic [FILL_W-1:0]     nibble_fill;
  logic                  error_flag;
  logic                  eos_q;

  // drain walk
  logic [BB_W-1:0]       cnt;
  logic [AW-1:0]         col_j;
  logic [DISK_IDX_W-1:0] disk_i;

  // output register
  logic               out_valid;
  logic [DIGIT_W-1:0] out_digit;
  logic               out_flag;
  logic               out_last;

  logic [DCNT_W-1:0] d_sat;
  logic [BB_W-1:0]   bb_sat;
  logic [DISK_W-1:0] dmask;
  logic [DISK_W-1:0] bits;
  logic [DISK_W-1:0] unk;
  logic [DISK_W-1:0] known;
  logic [DISK_W-1:0] col_word;
  logic              par;
  logic              unk_none;
  logic              unk_one;
  logic              err_set;
  logic [BB_W-1:0]   cnt_in;
  logic              drain;
  logic [DISK_IDX_W-1:0] first_disk;

  logic              j_last;
  logic [AW-1:0]     j_next;
  logic [DCNT_W-1:0] d_inc;
  logic [DCNT_W-1:0] d_skip;
  logic              last_disk;
  logic [DCNT_W-1:0] p_inc;
  logic              cur_bit;
  logic [1:0]        bit_pos;
  logic              emit_full;
  logic              out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_count <= RST_DISK_COUNT;
      block_bits <= RST_BLOCK_BITS;
      parity_odd <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_DISK_COUNT: disk_count <= cfg.data[DCNT_W-1:0];
        REG_BLOCK_BITS: block_bits <= cfg.data[BB_W-1:0];
        REG_PARITY_ODD: parity_odd <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // clamp the registers into range
  always_comb begin
    if (disk_count < DCNT_W'(2)) begin
      d_sat = DCNT_W'(2);
    end else if (disk_count > DCNT_W'(MAX_DISKS)) begin
      d_sat = DCNT_W'(MAX_DISKS);
    end else begin
      d_sat = disk_count;
    end
    if (block_bits == '0) begin
      bb_sat = BB_W'(1);
    end else if (block_bits > BB_W'(MAX_BLOCK_BITS)) begin
      bb_sat = BB_W'(MAX_BLOCK_BITS);
    end else begin
      bb_sat = block_bits;
    end
  end

  // column check and single-erasure repair
  always_comb begin
    for (int k = 0; k < DISK_W; k++) begin
      dmask[k] = (DCNT_W'(k) < d_sat);
    end
    bits     = column.disk_bits & dmask;
    unk      = column.unknown_mask & dmask;
    known    = bits & ~unk;
    par      = ^known;
    unk_none = (unk == '0);
    unk_one  = !unk_none && ((unk & (unk - DISK_W'(1))) == '0);
    if (unk_none) begin
      col_word = bits;
      err_set  = (par != parity_odd);
    end else if (unk_one) begin
      col_word = known | ((par != parity_odd) ? unk : '0);
      err_set  = 1'b0;
    end else begin
      col_word = known;
      err_set  = 1'b1;
    end
    cnt_in     = BB_W'(col_idx) + BB_W'(1);
    drain      = (cnt_in >= bb_sat) || column.end_of_set;
    first_disk = (parity_disk == '0) ? DISK_IDX_W'(1) : '0;
  end

  // walk: columns inside a disk, then the next non-parity disk
  always_comb begin
    j_last    = ((BB_W'(col_j) + BB_W'(1)) == cnt);
    j_next    = j_last ? '0 : col_j + AW'(1);
    d_inc     = DCNT_W'(disk_i) + DCNT_W'(1);
    d_skip    = (d_inc == DCNT_W'(parity_disk)) ? d_inc + DCNT_W'(1) : d_inc;
    last_disk = (d_skip >= d_sat);
    p_inc     = DCNT_W'(parity_disk) + DCNT_W'(1);
    cur_bit   = rdata[disk_i];
    bit_pos   = 2'd3 - nibble_fill[1:0];
    out_free  = !out_valid || digit.ready;
  end

  assign emit_full = cmd.push && (nibble_fill == FILL_FULL);

  assign rd_en   = cmd.rd_first || cmd.push;
  assign rd_addr = cmd.push ? j_next : col_j;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      stripe_mem[col_idx] <= col_word;
    end
    if (rd_en) begin
      rdata <= stripe_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx      <= '0;
      parity_disk  <= '0;
      nibble_accum <= '0;
      nibble_fill  <= '0;
      error_flag   <= 1'b0;
      eos_q        <= 1'b0;
      cnt          <= '0;
      col_j        <= '0;
      disk_i       <= '0;
    end else begin
      if (cmd.accept) begin
        error_flag <= error_flag | err_set;
        eos_q      <= column.end_of_set;
        cnt        <= cnt_in;
        if (drain) begin
          col_idx <= '0;
          col_j   <= '0;
          disk_i  <= first_disk;
        end else begin
          col_idx <= cnt_in[AW-1:0];
        end
      end
      if (cmd.push) begin
        if (nibble_fill == FILL_FULL) begin
          nibble_accum <= {cur_bit, {(DIGIT_W-1){1'b0}}};
          nibble_fill  <= FILL_W'(1);
        end else begin
          nibble_accum[bit_pos] <= cur_bit;
          nibble_fill           <= nibble_fill + FILL_W'(1);
        end
        if (j_last) begin
          col_j <= '0;
          if (last_disk) begin
            parity_disk <= (p_inc >= d_sat) ? '0 : p_inc[DISK_IDX_W-1:0];
          end else begin
            disk_i <= d_skip[DISK_IDX_W-1:0];
          end
        end else begin
          col_j <= j_next;
        end
      end
      if (cmd.final_emit) begin
        nibble_accum <= '0;
        nibble_fill  <= '0;
        col_idx      <= '0;
        parity_disk  <= '0;
        error_flag   <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_full || cmd.final_emit) begin
      out_valid <= 1'b1;
    end else if (digit.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_full || cmd.final_emit) begin
      out_digit <= nibble_accum;
      out_flag  <= error_flag;
      out_last  <= cmd.final_emit;
    end
  end

  assign digit.valid       = out_valid;
  assign digit.hex_digit   = out_digit;
  assign digit.set_invalid = out_flag;
  assign digit.last        = out_last;

  assign column.ready = cmd.in_ready;

  always_comb begin
    status             = '0;
    status.in_valid    = column.valid;
    status.drain       = drain;
    status.eos         = eos_q;
    status.stripe_done = j_last && last_disk;
    status.fill_full   = (nibble_fill == FILL_FULL);
    status.out_free    = out_free;
  end

endmodule
